// File: hdl/hrh_pkg.sv
// Shared types, constants and codes of the heading/roll hold servo mixer.
// No dependencies; the front, target, aileron and top-level files refer to this package.
package hrh_pkg;

  // Saturation limits of every servo pulse width.
  localparam logic [11:0] PULSE_MIN = 12'd1000;
  localparam logic [11:0] PULSE_MAX = 12'd2000;

  // 180/pi in Q16, used to turn Q3.13 radians into Q10.6 degrees.
  localparam logic signed [23:0] DEG_PER_RAD_Q16 = 24'sd3754937;

  // Half a turn and a full turn in Q10.6 degrees.
  localparam logic signed [17:0] DEG180_Q6 = 18'sd11520;
  localparam logic signed [17:0] DEG360_Q6 = 18'sd23040;

  // Flight mode codes; the fourth code behaves as manual.
  typedef enum logic [1:0] {
    MODE_MANUAL  = 2'd0,
    MODE_STAB    = 2'd1,
    MODE_HEADING = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CTL_MODE     = 3'd0,
    CFG_HDG_SETPOINT = 3'd1,
    CFG_BANK_LIMIT   = 3'd2,
    CFG_KP_ROLL      = 3'd3,
    CFG_KD_ROLL      = 3'd4,
    CFG_AIL_GAIN     = 3'd5,
    CFG_KP_HEAD      = 3'd6,
    CFG_K_ROLL_COMP  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         ctl_mode;
    logic signed [15:0] hdg_setpoint;
    logic [14:0]        bank_limit;
    logic signed [15:0] kp_roll;
    logic signed [15:0] kd_roll;
    logic signed [15:0] ail_gain;
    logic signed [15:0] kp_head;
    logic signed [15:0] k_roll_comp;
  } cfg_t;

  typedef struct packed {
    logic [11:0] aileron;
    logic [11:0] elevator;
    logic [11:0] throttle;
    logic [11:0] rudder;
  } sticks_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_rate;
    sticks_t            sticks;
  } in_item_t;

  // Front end result: wrapped heading error and degree-converted roll.
  typedef struct packed {
    logic signed [17:0] heading_err;
    logic signed [15:0] roll_deg;
    logic signed [31:0] rate_term;
    sticks_t            sticks;
  } front_t;

  // Roll target stage result.
  typedef struct packed {
    logic signed [15:0] target;
    logic signed [16:0] roll_err;
    logic signed [31:0] rate_term;
    sticks_t            sticks;
  } target_t;

  typedef struct packed {
    logic [11:0]        aileron_duty;
    logic [11:0]        elevator_duty;
    logic [11:0]        throttle_duty;
    logic [11:0]        rudder_duty;
    logic signed [15:0] roll_target_used;
  } out_item_t;

endpackage

// File: hdl/hrh_in_if.sv
// Input channel of the servo mixer: valid/ready handshake and one sensor item.
// Depends on nothing but plain logic types.
interface hrh_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] roll_rate;
  logic [11:0]        stick_aileron;
  logic [11:0]        stick_elevator;
  logic [11:0]        stick_throttle;
  logic [11:0]        stick_rudder;

  modport source (
    output valid, roll_angle, yaw_angle, roll_rate,
    output stick_aileron, stick_elevator, stick_throttle, stick_rudder,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, yaw_angle, roll_rate,
    input  stick_aileron, stick_elevator, stick_throttle, stick_rudder,
    output ready
  );
endinterface

// File: hdl/hrh_out_if.sv
// Output channel of the servo mixer: valid/ready handshake and one servo item.
// Depends on nothing but plain logic types.
interface hrh_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        aileron_duty;
  logic [11:0]        elevator_duty;
  logic [11:0]        throttle_duty;
  logic [11:0]        rudder_duty;
  logic signed [15:0] roll_target_used;

  modport source (
    output valid, aileron_duty, elevator_duty, throttle_duty, rudder_duty,
    output roll_target_used,
    input  ready
  );
  modport sink (
    input  valid, aileron_duty, elevator_duty, throttle_duty, rudder_duty,
    input  roll_target_used,
    output ready
  );
endinterface

// File: hdl/hrh_front.sv
// Front end, two stages: degree conversion products, then wrapped heading error.
// Depends on hrh_pkg.
module hrh_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hrh_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hrh_pkg::in_item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hrh_pkg::front_t out_item_o
);

  logic                a_valid_q, a_valid_d;
  logic signed [38:0]  a_yaw_p_q, a_yaw_p_d;
  logic signed [38:0]  a_roll_p_q, a_roll_p_d;
  logic signed [31:0]  a_comp_p_q, a_comp_p_d;
  logic signed [31:0]  a_rate_p_q, a_rate_p_d;
  hrh_pkg::sticks_t    a_sticks_q, a_sticks_d;
  logic                b_valid_q, b_valid_d;
  hrh_pkg::front_t     b_item_q, b_item_d;
  logic                adv_a, adv_b;
  logic signed [15:0]  yaw_deg;
  logic signed [16:0]  comp;
  logic signed [17:0]  h_raw;

  assign adv_b      = !b_valid_q || out_ready_i;
  assign adv_a      = !a_valid_q || adv_b;
  assign in_ready_o = adv_a;

  // Stage A: all four products of the sensor inputs.
  always_comb begin
    a_valid_d  = adv_a ? in_valid_i : a_valid_q;
    a_yaw_p_d  = a_yaw_p_q;
    a_roll_p_d = a_roll_p_q;
    a_comp_p_d = a_comp_p_q;
    a_rate_p_d = a_rate_p_q;
    a_sticks_d = a_sticks_q;
    if (adv_a && in_valid_i) begin
      a_yaw_p_d  = 39'(in_item_i.yaw_angle) * 39'(hrh_pkg::DEG_PER_RAD_Q16);
      a_roll_p_d = 39'(in_item_i.roll_angle) * 39'(hrh_pkg::DEG_PER_RAD_Q16);
      a_comp_p_d = 32'(in_item_i.roll_angle) * 32'(cfg_i.k_roll_comp);
      a_rate_p_d = 32'(in_item_i.roll_rate) * 32'(cfg_i.kd_roll);
      a_sticks_d = in_item_i.sticks;
    end
  end

  // Stage B: round to degrees, form the heading error and wrap it once.
  always_comb begin
    yaw_deg = 16'((a_yaw_p_q + 39'sd4194304) >>> 23);
    comp    = 17'((a_comp_p_q + 32'sd16384) >>> 15);
    h_raw   = 18'(cfg_i.hdg_setpoint) - 18'(yaw_deg) - 18'(comp);
    b_valid_d = adv_b ? a_valid_q : b_valid_q;
    b_item_d  = b_item_q;
    if (adv_b && a_valid_q) begin
      if (h_raw > hrh_pkg::DEG180_Q6) begin
        b_item_d.heading_err = h_raw - hrh_pkg::DEG360_Q6;
      end else if (h_raw < -hrh_pkg::DEG180_Q6) begin
        b_item_d.heading_err = h_raw + hrh_pkg::DEG360_Q6;
      end else begin
        b_item_d.heading_err = h_raw;
      end
      b_item_d.roll_deg  = 16'((a_roll_p_q + 39'sd4194304) >>> 23);
      b_item_d.rate_term = a_rate_p_q;
      b_item_d.sticks    = a_sticks_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_yaw_p_q  <= a_yaw_p_d;
    a_roll_p_q <= a_roll_p_d;
    a_comp_p_q <= a_comp_p_d;
    a_rate_p_q <= a_rate_p_d;
    a_sticks_q <= a_sticks_d;
    b_item_q   <= b_item_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule

// File: hdl/hrh_target.sv
// Roll target, two stages: heading gain product, then rounding, clamp and roll error.
// Depends on hrh_pkg.
module hrh_target (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hrh_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hrh_pkg::front_t  in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hrh_pkg::target_t out_item_o
);

  logic                c_valid_q, c_valid_d;
  logic signed [33:0]  c_prod_q, c_prod_d;
  logic signed [15:0]  c_roll_deg_q, c_roll_deg_d;
  logic signed [31:0]  c_rate_q, c_rate_d;
  hrh_pkg::sticks_t    c_sticks_q, c_sticks_d;
  logic                d_valid_q, d_valid_d;
  hrh_pkg::target_t    d_item_q, d_item_d;
  logic                adv_c, adv_d;
  logic signed [25:0]  t_full;
  logic signed [25:0]  t_lim;
  logic signed [15:0]  t_clamped;

  assign adv_d      = !d_valid_q || out_ready_i;
  assign adv_c      = !c_valid_q || adv_d;
  assign in_ready_o = adv_c;

  always_comb begin
    c_valid_d    = adv_c ? in_valid_i : c_valid_q;
    c_prod_d     = c_prod_q;
    c_roll_deg_d = c_roll_deg_q;
    c_rate_d     = c_rate_q;
    c_sticks_d   = c_sticks_q;
    if (adv_c && in_valid_i) begin
      c_prod_d     = 34'(cfg_i.kp_head) * 34'(in_item_i.heading_err);
      c_roll_deg_d = in_item_i.roll_deg;
      c_rate_d     = in_item_i.rate_term;
      c_sticks_d   = in_item_i.sticks;
    end
  end

  // Only heading hold has a nonzero target; zero always lies inside the clamp.
  always_comb begin
    t_lim = 26'($signed({1'b0, cfg_i.bank_limit}));
    if (cfg_i.ctl_mode == hrh_pkg::MODE_HEADING) begin
      t_full = 26'((c_prod_q + 34'sd128) >>> 8);
    end else begin
      t_full = '0;
    end
    if (t_full > t_lim) begin
      t_clamped = 16'(t_lim);
    end else if (t_full < -t_lim) begin
      t_clamped = 16'(-t_lim);
    end else begin
      t_clamped = 16'(t_full);
    end
    d_valid_d = adv_d ? c_valid_q : d_valid_q;
    d_item_d  = d_item_q;
    if (adv_d && c_valid_q) begin
      d_item_d.target    = t_clamped;
      d_item_d.roll_err  = 17'(c_roll_deg_q) - 17'(t_clamped);
      d_item_d.rate_term = c_rate_q;
      d_item_d.sticks    = c_sticks_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      c_valid_q <= c_valid_d;
      d_valid_q <= d_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_prod_q     <= c_prod_d;
    c_roll_deg_q <= c_roll_deg_d;
    c_rate_q     <= c_rate_d;
    c_sticks_q   <= c_sticks_d;
    d_item_q     <= d_item_d;
  end

  assign out_valid_o = d_valid_q;
  assign out_item_o  = d_item_q;

endmodule

// File: hdl/hrh_aileron.sv
// Aileron PD correction and output saturation, three stages ending in the output register.
// Depends on hrh_pkg.
module hrh_aileron (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hrh_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hrh_pkg::target_t   in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hrh_pkg::out_item_t out_item_o
);

  logic                 e_valid_q, e_valid_d;
  logic signed [38:0]   e_sum_q, e_sum_d;
  logic signed [15:0]   e_target_q, e_target_d;
  hrh_pkg::sticks_t     e_sticks_q, e_sticks_d;
  logic                 f_valid_q, f_valid_d;
  logic signed [54:0]   f_scaled_q, f_scaled_d;
  logic signed [15:0]   f_target_q, f_target_d;
  hrh_pkg::sticks_t     f_sticks_q, f_sticks_d;
  logic                 g_valid_q, g_valid_d;
  hrh_pkg::out_item_t   g_item_q, g_item_d;
  logic                 adv_e, adv_f, adv_g;
  logic signed [32:0]   pd_term;
  logic signed [32:0]   corr;
  logic signed [33:0]   ail_wide;
  logic                 ctrl_on;

  function automatic logic [11:0] sat_pulse(input logic signed [33:0] v);
    logic [11:0] r;
    if (v > 34'($signed({1'b0, hrh_pkg::PULSE_MAX}))) begin
      r = hrh_pkg::PULSE_MAX;
    end else if (v < 34'($signed({1'b0, hrh_pkg::PULSE_MIN}))) begin
      r = hrh_pkg::PULSE_MIN;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  assign adv_g      = !g_valid_q || out_ready_i;
  assign adv_f      = !f_valid_q || adv_g;
  assign adv_e      = !e_valid_q || adv_f;
  assign in_ready_o = adv_e;

  // Stage E: proportional product plus the rate term scaled by 64.
  always_comb begin
    pd_term    = 33'(cfg_i.kp_roll) * 33'(in_item_i.roll_err);
    e_valid_d  = adv_e ? in_valid_i : e_valid_q;
    e_sum_d    = e_sum_q;
    e_target_d = e_target_q;
    e_sticks_d = e_sticks_q;
    if (adv_e && in_valid_i) begin
      e_sum_d    = 39'(pd_term) + (39'(in_item_i.rate_term) <<< 6);
      e_target_d = in_item_i.target;
      e_sticks_d = in_item_i.sticks;
    end
  end

  // Stage F: overall correction scale.
  always_comb begin
    f_valid_d  = adv_f ? e_valid_q : f_valid_q;
    f_scaled_d = f_scaled_q;
    f_target_d = f_target_q;
    f_sticks_d = f_sticks_q;
    if (adv_f && e_valid_q) begin
      f_scaled_d = 55'(e_sum_q) * 55'(cfg_i.ail_gain);
      f_target_d = e_target_q;
      f_sticks_d = e_sticks_q;
    end
  end

  // Stage G: round the correction, add to the stick trim, saturate all four.
  always_comb begin
    ctrl_on  = (cfg_i.ctl_mode == hrh_pkg::MODE_STAB) ||
               (cfg_i.ctl_mode == hrh_pkg::MODE_HEADING);
    corr     = 33'((f_scaled_q + 55'sd2097152) >>> 22);
    ail_wide = 34'($signed({1'b0, f_sticks_q.aileron}));
    if (ctrl_on) begin
      ail_wide = ail_wide + 34'(corr);
    end
    g_valid_d = adv_g ? f_valid_q : g_valid_q;
    g_item_d  = g_item_q;
    if (adv_g && f_valid_q) begin
      g_item_d.aileron_duty     = sat_pulse(ail_wide);
      g_item_d.elevator_duty    = sat_pulse(34'($signed({1'b0, f_sticks_q.elevator})));
      g_item_d.throttle_duty    = sat_pulse(34'($signed({1'b0, f_sticks_q.throttle})));
      g_item_d.rudder_duty      = sat_pulse(34'($signed({1'b0, f_sticks_q.rudder})));
      g_item_d.roll_target_used = f_target_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
    end else begin
      e_valid_q <= e_valid_d;
      f_valid_q <= f_valid_d;
      g_valid_q <= g_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_sum_q    <= e_sum_d;
    e_target_q <= e_target_d;
    e_sticks_q <= e_sticks_d;
    f_scaled_q <= f_scaled_d;
    f_target_q <= f_target_d;
    f_sticks_q <= f_sticks_d;
    g_item_q   <= g_item_d;
  end

  assign out_valid_o = g_valid_q;
  assign out_item_o  = g_item_q;

endmodule

// File: hdl/heading_roll_hold_servo_mixer.sv
// Heading/roll hold servo mixer top level: configuration registers and the
// seven-stage pipeline. Depends on hrh_pkg, hrh_in_if, hrh_out_if, hrh_front,
// hrh_target and hrh_aileron.
//
//   Channel  Direction  Handshake        Contents
//   in_i     sink       valid / ready    roll, yaw, roll rate, four sticks
//   out_o    source     valid / ready    four servo duties, roll target used
//   cfg      write      cfg_we_i         index cfg_idx_i, data cfg_data_i
//
// An item passes seven register stages, A to G: the edge that accepts it loads
// stage A, and its result shows on out_o once it reaches stage G, the output
// register; a new item can enter every cycle while out_o is not stalled.
// Each stage holds one item and its own valid bit, and moves forward when the
// stage after it is empty or moving; a stall on out_o backs up stage by stage
// without losing or repeating any item, and in_i.ready drops only when all
// seven stages are full. Reset clears every valid bit and loads the register
// reset values; there is no clearing pass, so the block is ready right away.
//
// Arithmetic: the roll and yaw angles become Q10.6 degrees via a 180/pi
// multiply, the heading error is wrapped once into plus or minus 180 degrees,
// the heading gain gives a roll target clamped to the roll limit, and the PD
// sum scaled by the aileron gain is rounded once, half up, into pulse units.
module heading_roll_hold_servo_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrh_in_if.sink      in_i,
  hrh_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  hrh_pkg::cfg_t      cfg_q, cfg_d;
  hrh_pkg::in_item_t  in_item;
  hrh_pkg::front_t    front_item;
  hrh_pkg::target_t   target_item;
  hrh_pkg::out_item_t out_item;
  logic               front_valid, front_ready;
  logic               target_valid, target_ready;
  logic               out_valid;
  logic               in_ready;

  // Configuration writes land directly; the user must make them only while idle
  // (the block does not enforce this), so every stage may read the live registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        hrh_pkg::CFG_CTL_MODE:     cfg_d.ctl_mode     = cfg_data_i[1:0];
        hrh_pkg::CFG_HDG_SETPOINT: cfg_d.hdg_setpoint = cfg_data_i;
        hrh_pkg::CFG_BANK_LIMIT:   cfg_d.bank_limit   = cfg_data_i[14:0];
        hrh_pkg::CFG_KP_ROLL:      cfg_d.kp_roll      = cfg_data_i;
        hrh_pkg::CFG_KD_ROLL:      cfg_d.kd_roll      = cfg_data_i;
        hrh_pkg::CFG_AIL_GAIN:     cfg_d.ail_gain     = cfg_data_i;
        hrh_pkg::CFG_KP_HEAD:      cfg_d.kp_head      = cfg_data_i;
        hrh_pkg::CFG_K_ROLL_COMP:  cfg_d.k_roll_comp  = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ctl_mode     <= hrh_pkg::MODE_MANUAL;
      cfg_q.hdg_setpoint <= 16'sd0;
      cfg_q.bank_limit   <= 15'd1920;
      cfg_q.kp_roll      <= 16'sd256;
      cfg_q.kd_roll      <= 16'sd0;
      cfg_q.ail_gain     <= 16'sd256;
      cfg_q.kp_head      <= 16'sd256;
      cfg_q.k_roll_comp  <= 16'sd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Gather the input channel into the item struct.
  always_comb begin
    in_item.roll_angle      = in_i.roll_angle;
    in_item.yaw_angle       = in_i.yaw_angle;
    in_item.roll_rate       = in_i.roll_rate;
    in_item.sticks.aileron  = in_i.stick_aileron;
    in_item.sticks.elevator = in_i.stick_elevator;
    in_item.sticks.throttle = in_i.stick_throttle;
    in_item.sticks.rudder   = in_i.stick_rudder;
  end

  // Stages A and B: degree conversion and wrapped heading error.
  hrh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  // Stages C and D: roll target and roll error.
  hrh_target u_target (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (target_valid),
    .out_ready_i (target_ready),
    .out_item_o  (target_item)
  );

  // Stages E, F and G: PD correction, scaling and saturated outputs.
  hrh_aileron u_aileron (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (target_valid),
    .in_ready_o  (target_ready),
    .in_item_i   (target_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid;
  assign out_o.aileron_duty     = out_item.aileron_duty;
  assign out_o.elevator_duty    = out_item.elevator_duty;
  assign out_o.throttle_duty    = out_item.throttle_duty;
  assign out_o.rudder_duty      = out_item.rudder_duty;
  assign out_o.roll_target_used = out_item.roll_target_used;

`ifndef ASSERT_OFF
  // The input side can only be blocked when the whole pipeline is full
  // behind a stalled output.
  a_block_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_o.ready)
  ) else $error("input blocked while the pipeline has room");

  // The aileron output stays within the pulse limits whatever the correction.
  a_aileron_in_limits: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_item.aileron_duty >= hrh_pkg::PULSE_MIN &&
                   out_item.aileron_duty <= hrh_pkg::PULSE_MAX)
  ) else $error("aileron duty outside pulse limits");

  // The passed-through channels are saturated as well.
  a_sticks_in_limits: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_item.elevator_duty >= hrh_pkg::PULSE_MIN &&
                   out_item.elevator_duty <= hrh_pkg::PULSE_MAX &&
                   out_item.throttle_duty >= hrh_pkg::PULSE_MIN &&
                   out_item.throttle_duty <= hrh_pkg::PULSE_MAX &&
                   out_item.rudder_duty >= hrh_pkg::PULSE_MIN &&
                   out_item.rudder_duty <= hrh_pkg::PULSE_MAX)
  ) else $error("stick channel duty outside pulse limits");
`endif

endmodule
